>>> rtl/core/bcc_pkg.sv
// Shared types and constants for the oriented box against circle contact block.
package bcc_pkg;

	localparam int AXIS_FRAC_BITS_DEF = 14;
	localparam int MID_DEPTH = 16;
	localparam int OUT_DEPTH = 2;

	typedef struct packed {
		logic signed [31:0] box_x;
		logic signed [31:0] box_y;
		logic signed [15:0] axis_u_x;
		logic signed [15:0] axis_u_y;
		logic signed [15:0] axis_v_x;
		logic signed [15:0] axis_v_y;
		logic [30:0] half_width;
		logic [30:0] half_height;
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic [30:0] radius;
	} in_t;

	typedef struct packed {
		logic hit;
		logic degenerate;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [30:0] penetration;
	} out_t;

	typedef struct packed {
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic degen;
		logic far;
		logic [30:0] rad;
		logic [62:0] sq;
		logic ex_neg;
		logic ey_neg;
		logic [30:0] ex_mag;
		logic [30:0] ey_mag;
	} mid_t;

	typedef struct packed {
		logic valid;
		mid_t item;
	} mid_req_t;

endpackage

>>> rtl/core/bcc_fifo.sv
// Small register-based first-in first-out queue.
module bcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

>>> rtl/core/bcc_front.sv
// Front pipeline: box-space projection, clamping, contact point and squared offset.
module bcc_front #(
	parameter int AXIS_FRAC_BITS = bcc_pkg::AXIS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input bcc_pkg::in_t in_item,
	output bcc_pkg::mid_req_t out_req
);

	localparam int NST = 12;
	localparam logic signed [50:0] LIM = 51'sd2147483648;

	logic [NST-1:0] vld_q;

	bcc_pkg::in_t in_s1, in_s2, in_s3, in_s4, in_s5, in_s6, in_s7, in_s8, in_s9;
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [48:0] pux_s3, puy_s3, pvx_s3, pvy_s3;
	logic signed [49:0] lx_s4, ly_s4;
	logic signed [31:0] kx_s5, ky_s5;
	logic ins_s5, ins_s6, ins_s7;
	logic signed [47:0] qux_s6, qvx_s6, quy_s6, qvy_s6;
	logic signed [48:0] tx_s7, ty_s7;
	logic signed [49:0] px_s8, py_s8;
	logic signed [50:0] ex_s9, ey_s9;
	logic signed [31:0] cx_s9, cy_s9;
	bcc_pkg::mid_t m_s10, m_s11, m_s12, m10_c, m12_c;
	logic [61:0] sqx_s11, sqy_s11;

	logic signed [49:0] hwp_c, hwn_c, hhp_c, hhn_c, kx_c, ky_c;
	logic ins_c;
	logic signed [31:0] cx_c, cy_c;
	logic signed [50:0] exa_c, eya_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	always_comb begin
		hwp_c = $signed(50'(in_s4.half_width));
		hwn_c = -hwp_c;
		hhp_c = $signed(50'(in_s4.half_height));
		hhn_c = -hhp_c;
		kx_c = (lx_s4 < hwn_c) ? hwn_c : ((lx_s4 > hwp_c) ? hwp_c : lx_s4);
		ky_c = (ly_s4 < hhn_c) ? hhn_c : ((ly_s4 > hhp_c) ? hhp_c : ly_s4);
		ins_c = (lx_s4 >= hwn_c) && (lx_s4 <= hwp_c) && (ly_s4 >= hhn_c) && (ly_s4 <= hhp_c);
	end

	always_comb begin
		if (px_s8 > 50'sd2147483647) begin
			cx_c = 32'sh7fffffff;
		end else if (px_s8 < -50'sd2147483648) begin
			cx_c = 32'sh80000000;
		end else begin
			cx_c = 32'(px_s8);
		end
		if (py_s8 > 50'sd2147483647) begin
			cy_c = 32'sh7fffffff;
		end else if (py_s8 < -50'sd2147483648) begin
			cy_c = 32'sh80000000;
		end else begin
			cy_c = 32'(py_s8);
		end
	end

	always_comb begin
		exa_c = (ex_s9 < 0) ? -ex_s9 : ex_s9;
		eya_c = (ey_s9 < 0) ? -ey_s9 : ey_s9;
		m10_c.contact_x = cx_s9;
		m10_c.contact_y = cy_s9;
		m10_c.degen = (ex_s9 == '0) && (ey_s9 == '0);
		m10_c.far = !((ex_s9 > -LIM) && (ex_s9 < LIM) && (ey_s9 > -LIM) && (ey_s9 < LIM));
		m10_c.rad = in_s9.radius;
		m10_c.sq = '0;
		m10_c.ex_neg = ex_s9 < 0;
		m10_c.ey_neg = ey_s9 < 0;
		m10_c.ex_mag = 31'(exa_c);
		m10_c.ey_mag = 31'(eya_c);
	end

	always_comb begin
		m12_c = m_s11;
		m12_c.sq = 63'(sqx_s11) + 63'(sqy_s11);
	end

	always_ff @(posedge clk) begin
		in_s1 <= in_item;
		in_s2 <= in_s1;
		dx_s2 <= 33'(in_s1.centre_x) - 33'(in_s1.box_x);
		dy_s2 <= 33'(in_s1.centre_y) - 33'(in_s1.box_y);
		in_s3 <= in_s2;
		pux_s3 <= 49'(dx_s2) * 49'(in_s2.axis_u_x);
		puy_s3 <= 49'(dy_s2) * 49'(in_s2.axis_u_y);
		pvx_s3 <= 49'(dx_s2) * 49'(in_s2.axis_v_x);
		pvy_s3 <= 49'(dy_s2) * 49'(in_s2.axis_v_y);
		in_s4 <= in_s3;
		lx_s4 <= (50'(pux_s3) + 50'(puy_s3)) >>> AXIS_FRAC_BITS;
		ly_s4 <= (50'(pvx_s3) + 50'(pvy_s3)) >>> AXIS_FRAC_BITS;
		in_s5 <= in_s4;
		kx_s5 <= 32'(kx_c);
		ky_s5 <= 32'(ky_c);
		ins_s5 <= ins_c;
		in_s6 <= in_s5;
		ins_s6 <= ins_s5;
		qux_s6 <= 48'(kx_s5) * 48'(in_s5.axis_u_x);
		qvx_s6 <= 48'(ky_s5) * 48'(in_s5.axis_v_x);
		quy_s6 <= 48'(kx_s5) * 48'(in_s5.axis_u_y);
		qvy_s6 <= 48'(ky_s5) * 48'(in_s5.axis_v_y);
		in_s7 <= in_s6;
		ins_s7 <= ins_s6;
		tx_s7 <= (49'(qux_s6) + 49'(qvx_s6)) >>> AXIS_FRAC_BITS;
		ty_s7 <= (49'(quy_s6) + 49'(qvy_s6)) >>> AXIS_FRAC_BITS;
		in_s8 <= in_s7;
		px_s8 <= ins_s7 ? 50'(in_s7.centre_x) : 50'(in_s7.box_x) + 50'(tx_s7);
		py_s8 <= ins_s7 ? 50'(in_s7.centre_y) : 50'(in_s7.box_y) + 50'(ty_s7);
		in_s9 <= in_s8;
		ex_s9 <= 51'(in_s8.centre_x) - 51'(px_s8);
		ey_s9 <= 51'(in_s8.centre_y) - 51'(py_s8);
		cx_s9 <= cx_c;
		cy_s9 <= cy_c;
		m_s10 <= m10_c;
		m_s11 <= m_s10;
		sqx_s11 <= 62'(m_s10.ex_mag) * 62'(m_s10.ex_mag);
		sqy_s11 <= 62'(m_s10.ey_mag) * 62'(m_s10.ey_mag);
		m_s12 <= m12_c;
	end

	assign out_req.valid = vld_q[NST-1];
	assign out_req.item = m_s12;

endmodule

>>> rtl/core/bcc_back.sv
// Back pipeline: square root of the squared offset, penetration and unit direction.
module bcc_back #(
	parameter int AXIS_FRAC_BITS = bcc_pkg::AXIS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input bcc_pkg::mid_req_t in_req,
	output logic out_valid,
	output bcc_pkg::out_t out_item
);

	localparam int SQ_ST = 32;
	localparam int DIV_ST = AXIS_FRAC_BITS + 1;

	typedef struct packed {
		logic hit;
		logic degen;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0] pen;
		logic ex_neg;
		logic ey_neg;
		logic zero_dir;
	} dv_info_t;

	function automatic logic signed [15:0] dir_sat(input logic [31:0] q, input logic neg);
		logic signed [15:0] r;
		if (neg) begin
			r = (q > 32'd32768) ? 16'sh8000 : 16'(-q);
		end else begin
			r = (q > 32'd32767) ? 16'sh7fff : 16'(q);
		end
		return r;
	endfunction

	logic [SQ_ST:0] sv_q;
	logic [DIV_ST:0] dv_q;
	logic fv_q;

	bcc_pkg::mid_t sm_s [SQ_ST+1];
	logic [63:0] sx_s [SQ_ST+1];
	logic [63:0] sr_s [SQ_ST+1];
	logic [63:0] sx_c [SQ_ST];
	logic [63:0] sr_c [SQ_ST];

	dv_info_t di_s [DIV_ST+1];
	logic [31:0] dd_s [DIV_ST+1];
	logic [63:0] rx_s [DIV_ST+1];
	logic [63:0] ry_s [DIV_ST+1];
	logic [31:0] qx_s [DIV_ST+1];
	logic [31:0] qy_s [DIV_ST+1];
	logic [63:0] rx_c [DIV_ST];
	logic [63:0] ry_c [DIV_ST];
	logic [31:0] qx_c [DIV_ST];
	logic [31:0] qy_c [DIV_ST];

	logic [31:0] dist_c;
	logic signed [32:0] pd_c;
	logic hit_c;
	dv_info_t info_c;
	bcc_pkg::out_t fo_c, fo_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= '0;
			dv_q <= '0;
			fv_q <= 1'b0;
		end else if (en) begin
			sv_q <= {sv_q[SQ_ST-1:0], in_req.valid};
			dv_q <= {dv_q[DIV_ST-1:0], sv_q[SQ_ST]};
			fv_q <= dv_q[DIV_ST];
		end
	end

	always_comb begin
		logic [63:0] t;
		logic [63:0] b;
		for (int k = 0; k < SQ_ST; k++) begin
			b = 64'd1 << (62 - 2 * k);
			t = sr_s[k] + b;
			if (sx_s[k] >= t) begin
				sx_c[k] = sx_s[k] - t;
				sr_c[k] = (sr_s[k] >> 1) + b;
			end else begin
				sx_c[k] = sx_s[k];
				sr_c[k] = sr_s[k] >> 1;
			end
		end
	end

	always_comb begin
		dist_c = sr_s[SQ_ST][31:0];
		pd_c = $signed({2'b00, sm_s[SQ_ST].rad}) - $signed({1'b0, dist_c});
		hit_c = !sm_s[SQ_ST].far && (pd_c > 0);
		info_c.hit = hit_c;
		info_c.degen = sm_s[SQ_ST].degen;
		info_c.cx = sm_s[SQ_ST].contact_x;
		info_c.cy = sm_s[SQ_ST].contact_y;
		info_c.pen = hit_c ? pd_c[30:0] : '0;
		info_c.ex_neg = sm_s[SQ_ST].ex_neg;
		info_c.ey_neg = sm_s[SQ_ST].ey_neg;
		info_c.zero_dir = !hit_c || sm_s[SQ_ST].degen;
	end

	always_comb begin
		logic [63:0] dsh;
		logic gx;
		logic gy;
		for (int i = 0; i < DIV_ST; i++) begin
			dsh = 64'(dd_s[i]) << (AXIS_FRAC_BITS - i);
			gx = rx_s[i] >= dsh;
			gy = ry_s[i] >= dsh;
			rx_c[i] = gx ? rx_s[i] - dsh : rx_s[i];
			ry_c[i] = gy ? ry_s[i] - dsh : ry_s[i];
			qx_c[i] = {qx_s[i][30:0], gx};
			qy_c[i] = {qy_s[i][30:0], gy};
		end
	end

	always_comb begin
		fo_c.hit = di_s[DIV_ST].hit;
		fo_c.degenerate = di_s[DIV_ST].degen;
		fo_c.contact_x = di_s[DIV_ST].cx;
		fo_c.contact_y = di_s[DIV_ST].cy;
		fo_c.penetration = di_s[DIV_ST].pen;
		fo_c.dir_x = di_s[DIV_ST].zero_dir ? '0 : dir_sat(qx_s[DIV_ST], di_s[DIV_ST].ex_neg);
		fo_c.dir_y = di_s[DIV_ST].zero_dir ? '0 : dir_sat(qy_s[DIV_ST], di_s[DIV_ST].ey_neg);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s[0] <= in_req.item;
			sx_s[0] <= 64'(in_req.item.sq);
			sr_s[0] <= '0;
			for (int k = 0; k < SQ_ST; k++) begin
				sm_s[k+1] <= sm_s[k];
				sx_s[k+1] <= sx_c[k];
				sr_s[k+1] <= sr_c[k];
			end
			di_s[0] <= info_c;
			dd_s[0] <= dist_c;
			rx_s[0] <= 64'(sm_s[SQ_ST].ex_mag) << AXIS_FRAC_BITS;
			ry_s[0] <= 64'(sm_s[SQ_ST].ey_mag) << AXIS_FRAC_BITS;
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			for (int i = 0; i < DIV_ST; i++) begin
				di_s[i+1] <= di_s[i];
				dd_s[i+1] <= dd_s[i];
				rx_s[i+1] <= rx_c[i];
				ry_s[i+1] <= ry_c[i];
				qx_s[i+1] <= qx_c[i];
				qy_s[i+1] <= qy_c[i];
			end
			fo_s <= fo_c;
		end
	end

	assign out_valid = fv_q;
	assign out_item = fo_s;

endmodule

>>> rtl/core/box_circle_contact.sv
// Top level of the oriented box against circle contact block.
// Throughput: one request per cycle, sustained while results are popped.
// The square root takes 32 stages and each direction divider AXIS_FRAC_BITS + 1 stages.
// Reset clears all valid bits, queue pointers and the credit count; results come back empty.
module box_circle_contact #(
	parameter int AXIS_FRAC_BITS = bcc_pkg::AXIS_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input bcc_pkg::in_t item,
	output logic empty,
	input logic pop,
	output bcc_pkg::out_t result
);

	localparam int TW = $clog2(bcc_pkg::MID_DEPTH + 1);

	logic [TW-1:0] tok_q;
	logic acc;
	logic en;
	logic mid_empty;
	logic mid_pop;
	logic out_full;
	bcc_pkg::mid_req_t front_req;
	bcc_pkg::mid_t mid_head;
	bcc_pkg::mid_req_t back_req;
	logic back_valid;
	bcc_pkg::out_t back_item;

	assign full = (tok_q == TW'(bcc_pkg::MID_DEPTH));
	assign acc = push && !full;
	assign en = !out_full;
	assign mid_pop = en && !mid_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_q + TW'(acc) - TW'(mid_pop);
		end
	end

	bcc_front #(
		.AXIS_FRAC_BITS(AXIS_FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(acc),
		.in_item(item),
		.out_req(front_req)
	);

	bcc_fifo #(
		.WIDTH($bits(bcc_pkg::mid_t)),
		.DEPTH(bcc_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(front_req.valid),
		.wdata(front_req.item),
		.pop(mid_pop),
		.rdata(mid_head),
		.empty(mid_empty),
		.full()
	);

	assign back_req.valid = mid_pop;
	assign back_req.item = mid_head;

	bcc_back #(
		.AXIS_FRAC_BITS(AXIS_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_req(back_req),
		.out_valid(back_valid),
		.out_item(back_item)
	);

	bcc_fifo #(
		.WIDTH($bits(bcc_pkg::out_t)),
		.DEPTH(bcc_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(en && back_valid),
		.wdata(back_item),
		.pop(pop),
		.rdata(result),
		.empty(empty),
		.full(out_full)
	);

endmodule

>>> rtl/core/bcc_checker.sv
// Port-level assertions for the contact block and their binding to the top level.
module bcc_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input bcc_pkg::out_t result
);

	a_reset_state: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not empty after reset");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed before pop");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.hit |-> result.penetration == '0 && result.dir_x == '0
			&& result.dir_y == '0)
		else $error("miss carries penetration or direction");

	a_degen_dir: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.degenerate |-> result.dir_x == '0 && result.dir_y == '0)
		else $error("degenerate result has a direction");

	a_hit_pen: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.hit |-> result.penetration != '0)
		else $error("hit with zero penetration");

endmodule

bind box_circle_contact bcc_checker u_bcc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.full(full),
	.empty(empty),
	.pop(pop),
	.result(result)
);
